/* design/dssd_pkg.sv */
// ----------------------------------------------------------------------------
// Difference sample stream decoder package
// Shared item types and constants for the decoder modules.
// ----------------------------------------------------------------------------
package dssd_pkg;

	// Saturation limit of the per-packet sample count.
	localparam logic [11:0] MAX_SAMPLES = 12'd2048;

	// One payload byte with its packet marks.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       compressed;
		logic       last_byte;
	} in_t;

	// One decoded sample, or a size-error marker at a short packet end.
	typedef struct packed {
		logic signed [31:0] sample;
		logic [11:0]        sample_count;
		logic               end_of_packet;
		logic               size_error;
	} out_t;

endpackage

/* design/dssd_decode.sv */
// ----------------------------------------------------------------------------
// Decoder core
// Token assembly state, running value and sample count, with the decode logic
// that turns one registered byte into at most one result.
// ----------------------------------------------------------------------------
module dssd_decode (
	input  logic           clk,
	input  logic           arst_n,
	input  dssd_pkg::in_t  item,
	input  logic           advance,
	output logic           res_valid,
	output dssd_pkg::out_t res
);

	typedef enum logic [1:0] {
		PH_START = 2'd0,
		PH_ONE   = 2'd1,
		PH_TWO   = 2'd2
	} phase_t;

	phase_t      phase_q;
	logic        long_q;
	logic [15:0] held_q;
	logic [31:0] running_q;
	logic [11:0] count_q;

	logic [15:0] diff;
	logic [31:0] diff_sum;
	logic [23:0] word;
	logic [31:0] abs_val;
	logic [31:0] plain_val;
	logic [11:0] count_inc;
	logic        done;
	logic [31:0] value;

	assign diff      = {held_q[6:0], item.data_byte, 1'b0};
	assign diff_sum  = running_q + {{16{diff[15]}}, diff};
	assign word      = {held_q, item.data_byte};
	assign abs_val   = {{8{word[22]}}, word[22:0], 1'b0};
	assign plain_val = {{8{word[23]}}, word};
	assign count_inc = (count_q < dssd_pkg::MAX_SAMPLES) ? count_q + 12'd1 : count_q;

	always_comb begin
		done  = 1'b0;
		value = '0;
		case (phase_q)
			PH_ONE: begin
				if (!long_q) begin
					done  = 1'b1;
					value = diff_sum;
				end
			end
			PH_TWO: begin
				done  = 1'b1;
				value = item.compressed ? abs_val : plain_val;
			end
			default: begin
				done = 1'b0;
			end
		endcase
	end

	always_comb begin
		res_valid = done || item.last_byte;
		res.sample        = done ? value : '0;
		res.sample_count  = done ? count_inc : count_q;
		res.end_of_packet = item.last_byte;
		res.size_error    = !done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_START;
			long_q    <= 1'b0;
			running_q <= '0;
			count_q   <= '0;
		end else if (advance) begin
			if (item.last_byte) begin
				phase_q   <= PH_START;
				long_q    <= 1'b0;
				running_q <= '0;
				count_q   <= '0;
			end else begin
				if (done) begin
					count_q <= count_inc;
				end
				case (phase_q)
					PH_ONE: begin
						if (!long_q) begin
							running_q <= diff_sum;
							phase_q   <= PH_START;
						end else begin
							phase_q <= PH_TWO;
						end
					end
					PH_TWO: begin
						if (item.compressed) begin
							running_q <= abs_val;
						end
						phase_q <= PH_START;
					end
					default: begin
						long_q  <= item.compressed ? item.data_byte[7] : 1'b1;
						phase_q <= PH_ONE;
					end
				endcase
			end
		end
	end

	// Held bytes are payload: each is written before the phase that reads it.
	always_ff @(posedge clk) begin
		if (advance) begin
			case (phase_q)
				PH_ONE: begin
					held_q <= {held_q[7:0], item.data_byte};
				end
				PH_TWO: begin
					held_q <= held_q;
				end
				default: begin
					held_q <= {8'd0, item.data_byte};
				end
			endcase
		end
	end

endmodule

/* design/dssd_out_reg.sv */
// ----------------------------------------------------------------------------
// Result register
// Holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module dssd_out_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  dssd_pkg::out_t load_data,
	output logic           result_valid,
	input  logic           result_ready,
	output dssd_pkg::out_t result,
	output logic           free
);

	logic           valid_q;
	dssd_pkg::out_t data_q;

	assign free         = !valid_q || result_ready;
	assign result_valid = valid_q;
	assign result       = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (result_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_data;
		end
	end

endmodule

/* design/difference_sample_stream_decoder.sv */
// ----------------------------------------------------------------------------
// Difference sample stream decoder
// Rebuilds signed samples from a byte stream of plain or compressed tokens.
// ----------------------------------------------------------------------------
// Usage: payload bytes arrive on the item channel, one byte per transfer,
// each with its compressed flag and a mark on the last byte of the packet.
// Decoded samples leave on the result channel, one transfer per completed
// token, carrying the per-packet sample count and an end-of-packet mark.
// A packet that ends inside a token yields a single result with size_error
// set and a zero sample; the partial token is dropped.
// Path: a byte accepted into the input register is decoded from it, and its
// result is loaded into the result register, from which it is transferred.
// Throughput: one byte per cycle while the result register has room; the
// decode is one add between the input register and the result register,
// so bytes stream back to back.
// Stalls: while a result waits, the input register still drains bytes that
// produce no result; a byte that completes a token or ends the packet waits
// in the input register, and item_ready drops only once it is held.
// Reset: arst_n clears the token phase, running value, sample count and
// both valid flags; the block starts at a token boundary of a new packet.
// ----------------------------------------------------------------------------
module difference_sample_stream_decoder (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_ready,
	input  dssd_pkg::in_t  item,
	output logic           result_valid,
	input  logic           result_ready,
	output dssd_pkg::out_t result
);

	// Input register stage.
	logic          valid_s1;
	dssd_pkg::in_t item_s1;

	logic           advance;
	logic           out_free;
	logic           res_valid;
	dssd_pkg::out_t res;

	// The registered byte moves on when its result, if any, has room.
	assign advance    = valid_s1 && (out_free || !res_valid);
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && item_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	// Token assembly and sample arithmetic.
	dssd_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item_s1),
		.advance  (advance),
		.res_valid(res_valid),
		.res      (res)
	);

	// Result register towards the receiver.
	dssd_out_reg u_out_reg (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (advance && res_valid),
		.load_data   (res),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result),
		.free        (out_free)
	);

endmodule

/* design/dssd_checker.sv */
// ----------------------------------------------------------------------------
// Decoder port checker
// Checks the result channel of the decoder over time, bound to the top level.
// ----------------------------------------------------------------------------
module dssd_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           result_valid,
	input logic           result_ready,
	input dssd_pkg::out_t result
);

	// A stalled result keeps its value until it is transferred.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// A size error only marks the end of a packet and carries no sample.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.size_error |-> result.end_of_packet && result.sample == 0)
		else $error("size error result malformed");

	// A decoded sample is always counted.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.size_error |-> result.sample_count != 12'd0)
		else $error("decoded sample with zero count");

	// The count never passes its saturation limit.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.sample_count <= dssd_pkg::MAX_SAMPLES)
		else $error("sample count above limit");

endmodule

bind difference_sample_stream_decoder dssd_checker u_dssd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.result      (result)
);
